>>> rtl/ildl_pkg.sv
// Shared types and codes for the indexed insert/delete list.
// Used by ildl_cell and indexed_insert_delete_list. No dependencies.
`default_nettype none

package ildl_pkg;

  // Fixed field widths
  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int LEN_W  = 5;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam int DEFAULT_CAPACITY = 16;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSHB  = 3'd2;
  localparam logic [OP_W-1:0] OP_POPB   = 3'd3;
  localparam logic [OP_W-1:0] OP_PUSHF  = 3'd4;
  localparam logic [OP_W-1:0] OP_POPF   = 3'd5;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd6;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd7;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // What the cell row does this cycle
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_OPEN,
    KIND_CLOSE
  } kind_e;

  // Command broadcast to every cell
  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/ildl_cell.sv
// One storage cell of the list: holds one word and trades it with its neighbors.
// Depends on ildl_pkg.
`default_nettype none

module ildl_cell #(
  parameter int INDEX = 0,
  parameter int CMPW  = 5
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ildl_pkg::cell_cmd_t         cmd_i,
  input  wire logic [CMPW-1:0]             pos_i,
  input  wire logic [CMPW-1:0]             count_i,
  input  wire logic [CMPW-1:0]             tgt_i,
  input  wire logic [ildl_pkg::WORD_W-1:0] left_i,
  input  wire logic [ildl_pkg::WORD_W-1:0] right_i,
  output logic      [ildl_pkg::WORD_W-1:0] value_o,
  output logic      [ildl_pkg::WORD_W-1:0] tap_o
);
  import ildl_pkg::*;

  localparam logic [CMPW-1:0] IDX    = CMPW'(INDEX);
  localparam logic [CMPW-1:0] IDX_P1 = CMPW'(INDEX + 1);

  logic [WORD_W-1:0] value_q, value_d;

  // Pick the next word from the broadcast command and this cell's place
  always_comb begin
    value_d = value_q;
    case (cmd_i.kind)
      KIND_WRITE: begin
        if (IDX == pos_i) value_d = cmd_i.word;
      end
      KIND_OPEN: begin
        if (IDX == pos_i) value_d = cmd_i.word;
        else if (IDX > pos_i && IDX <= count_i) value_d = left_i;
      end
      KIND_CLOSE: begin
        if (IDX >= pos_i && IDX_P1 < count_i) value_d = right_i;
        else if (IDX_P1 == count_i) value_d = '0;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  // Drive the read tap only when this cell is the target
  assign tap_o   = (IDX == tgt_i) ? value_q : '0;
  assign value_o = value_q;

endmodule

`default_nettype wire

>>> rtl/indexed_insert_delete_list.sv
// Top level of the indexed insert/delete list: request decode, cell row, result register.
// Depends on ildl_pkg and ildl_cell.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+------------------------
//  in      | in_valid_i, in_ready_o, op_i, position_i,  | one request beat
//          | word_in_i                                  |
//  out     | out_valid_o, out_ready_i, word_out_o,      | one result beat
//          | length_o, status_o                         |
//
// For each accepted request the whole cell row shifts, loads or clears at
// the accepting edge, and the result is loaded into the output register at that same edge.
// A new request is taken every cycle while the output register is empty or drained.
// A stalled result holds in_ready_o low until it is taken.
// Reset clears every cell and the count; no clearing pass is needed.
`default_nettype none

module indexed_insert_delete_list #(
  parameter int CAPACITY = ildl_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [ildl_pkg::OP_W-1:0]          op_i,
  input  wire logic [ildl_pkg::POS_W-1:0]         position_i,
  input  wire logic signed [ildl_pkg::WORD_W-1:0] word_in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [ildl_pkg::WORD_W-1:0]      word_out_o,
  output logic [ildl_pkg::LEN_W-1:0]              length_o,
  output logic [ildl_pkg::ST_W-1:0]               status_o
);
  import ildl_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] CAP_X = CMPW'(CAPACITY);

  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q;
  logic [WORD_W-1:0] word_q;
  logic [LEN_W-1:0]  len_q;
  logic [ST_W-1:0]   st_q;

  logic              in_fire;
  logic [CMPW-1:0]   pos_x, cnt_x, tgt_x, tgt_pos;
  kind_e             kind;
  logic              rd;
  logic [ST_W-1:0]   st_d;
  cell_cmd_t         cmd;
  logic [WORD_W-1:0] rd_word;

  logic [WORD_W-1:0] vals [CAPACITY];
  logic [WORD_W-1:0] taps [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_x = CMPW'(position_i);
  assign cnt_x = CMPW'(count_q);

  // Decode the request against the current count
  always_comb begin
    kind    = KIND_NONE;
    rd      = 1'b0;
    st_d    = ST_OK;
    tgt_pos = pos_x;
    unique case (op_i)
      OP_READ: begin
        if (pos_x < cnt_x) rd = 1'b1;
        else st_d = ST_RANGE;
      end
      OP_WRITE: begin
        if (pos_x < cnt_x) kind = KIND_WRITE;
        else st_d = ST_RANGE;
      end
      OP_PUSHB: begin
        tgt_pos = cnt_x;
        if (cnt_x >= CAP_X) st_d = ST_FULL;
        else kind = KIND_OPEN;
      end
      OP_POPB: begin
        tgt_pos = cnt_x - CMPW'(1);
        if (cnt_x == '0) st_d = ST_EMPTY;
        else begin
          kind = KIND_CLOSE;
          rd   = 1'b1;
        end
      end
      OP_PUSHF: begin
        tgt_pos = '0;
        if (cnt_x >= CAP_X) st_d = ST_FULL;
        else kind = KIND_OPEN;
      end
      OP_POPF: begin
        tgt_pos = '0;
        if (cnt_x == '0) st_d = ST_EMPTY;
        else begin
          kind = KIND_CLOSE;
          rd   = 1'b1;
        end
      end
      OP_INSERT: begin
        if (cnt_x >= CAP_X) st_d = ST_FULL;
        else if (pos_x > cnt_x) st_d = ST_RANGE;
        else kind = KIND_OPEN;
      end
      OP_REMOVE: begin
        if (cnt_x == '0) st_d = ST_EMPTY;
        else if (pos_x >= cnt_x) st_d = ST_RANGE;
        else begin
          kind = KIND_CLOSE;
          rd   = 1'b1;
        end
      end
      default: st_d = ST_OK;
    endcase
  end

  assign tgt_x    = tgt_pos;
  assign cmd.kind = in_fire ? kind : KIND_NONE;
  assign cmd.word = word_in_i;

  // Cell row: each cell sees its neighbors' words
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = vals[i+1];
    end
    ildl_cell #(
      .INDEX (i),
      .CMPW  (CMPW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pos_i   (tgt_x),
      .count_i (cnt_x),
      .tgt_i   (tgt_x),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (vals[i]),
      .tap_o   (taps[i])
    );
  end

  // Merge the read taps; only the target cell drives a nonzero word
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | taps[k];
    end
  end

  // Advance the count on accepted open or close
  always_comb begin
    count_d = count_q;
    if (cmd.kind == KIND_OPEN) count_d = count_q + CW'(1);
    else if (cmd.kind == KIND_CLOSE) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      word_q <= rd ? rd_word : '0;
      len_q  <= LEN_W'(count_d);
      st_q   <= st_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_out_o  = word_q;
  assign length_o    = len_q;
  assign status_o    = st_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CAP_X)
    else $error("entry count above capacity");

  a_refused_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && st_d != ST_OK |=> $stable(count_q))
    else $error("refused request changed the count");

  a_refused_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && st_q != ST_OK |-> word_q == '0)
    else $error("refused request returned a nonzero word");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire
